// ===== design/btbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btbp_pkg
// Types, codes and a helper function shared by the branch target buffer files.
// ----------------------------------------------------------------------------
package btbp_pkg;

    localparam int PC_W       = 16;
    localparam int TGT_W      = 16;
    localparam int SEQ_W      = 8;
    localparam int STAT_W     = 32;
    localparam int FUNC_W     = 2;
    localparam int MODE_W     = 2;
    localparam int DIR_W      = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PREDICT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_STATIC_NT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STATIC_T  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ONE_BIT   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TWO_BIT   = 2'd3;
    localparam logic [MODE_W-1:0] MODE_RESET     = MODE_TWO_BIT;

    localparam logic [DIR_W-1:0] DIR_SNT = 2'd0;
    localparam logic [DIR_W-1:0] DIR_WNT = 2'd1;
    localparam logic [DIR_W-1:0] DIR_WT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_ST  = 2'd3;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_MODE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic miss;
        logic result;
        logic out_full;
    } status_t;

    function automatic logic [DIR_W-1:0] next_dir(
        input logic [DIR_W-1:0]  cur,
        input logic              correct,
        input logic [MODE_W-1:0] mode
    );
        logic [DIR_W-1:0] nd;
        begin
            if (mode == MODE_ONE_BIT)
            begin
                if (correct)
                    nd = cur;
                else
                    nd = cur[1] ? DIR_SNT : DIR_ST;
            end
            else
            begin
                case (cur)
                    DIR_ST:  nd = correct ? DIR_ST  : DIR_WT;
                    DIR_WT:  nd = correct ? DIR_ST  : DIR_SNT;
                    DIR_WNT: nd = correct ? DIR_SNT : DIR_ST;
                    default: nd = correct ? DIR_SNT : DIR_WNT;
                endcase
            end
            return nd;
        end
    endfunction

endpackage

// ===== design/btbp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btbp_if
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface btbp_req_if;
    logic                          valid;
    logic                          ready;
    logic [btbp_pkg::FUNC_W-1:0]   func;
    logic [btbp_pkg::PC_W-1:0]     pc;
    logic [btbp_pkg::TGT_W-1:0]    target;
    logic                          was_correct;
    logic [btbp_pkg::SEQ_W-1:0]    seq_tag;

    modport source (output valid, func, pc, target, was_correct, seq_tag, input ready);
    modport sink   (input valid, func, pc, target, was_correct, seq_tag, output ready);
endinterface

interface btbp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [btbp_pkg::PC_W-1:0]     next_pc;
    logic                          predicted_taken;
    logic                          table_hit;
    logic [btbp_pkg::SEQ_W-1:0]    seq_tag_out;
    logic [btbp_pkg::STAT_W-1:0]   total_count;
    logic [btbp_pkg::STAT_W-1:0]   correct_count;

    modport source (output valid, next_pc, predicted_taken, table_hit, seq_tag_out,
                    total_count, correct_count, input ready);
    modport sink   (input valid, next_pc, predicted_taken, table_hit, seq_tag_out,
                    total_count, correct_count, output ready);
endinterface

// ===== design/btbp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btbp_ctrl
// Sequencer for one request word: accept, tag scan, then commit.
// ----------------------------------------------------------------------------
module btbp_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic               rsp_ready,
    input  btbp_pkg::status_t  status,
    output btbp_pkg::cmd_t     cmd
);

    btbp_pkg::state_t state_reg;
    btbp_pkg::state_t state_next;
    logic             out_blocked;

    assign out_blocked = status.result && status.out_full && !rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= btbp_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            btbp_pkg::ST_IDLE:
            begin
                if (req_valid)
                    state_next = btbp_pkg::ST_SCAN;
            end
            btbp_pkg::ST_SCAN:
            begin
                if (status.hit || status.miss)
                    state_next = btbp_pkg::ST_EXEC;
            end
            btbp_pkg::ST_EXEC:
            begin
                if (!out_blocked)
                    state_next = btbp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = btbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd.load   = 1'b0;
        cmd.scan   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            btbp_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            btbp_pkg::ST_SCAN:
            begin
                cmd.scan = !(status.hit || status.miss);
            end
            btbp_pkg::ST_EXEC:
            begin
                cmd.commit = !out_blocked;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/btbp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btbp_dp
// Entry memories, tag scan, direction update, counters and response register.
// ----------------------------------------------------------------------------
module btbp_dp
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int ADDR_BITS     = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  btbp_pkg::cmd_t                    cmd,
    output btbp_pkg::status_t                 status,
    input  logic [btbp_pkg::MODE_W-1:0]       mode,
    input  logic [btbp_pkg::FUNC_W-1:0]       req_func,
    input  logic [btbp_pkg::PC_W-1:0]         req_pc,
    input  logic [btbp_pkg::TGT_W-1:0]        req_target,
    input  logic                              req_was_correct,
    input  logic [btbp_pkg::SEQ_W-1:0]        req_seq_tag,
    input  logic                              rsp_ready,
    output logic                              rsp_valid,
    output logic [btbp_pkg::PC_W-1:0]         rsp_next_pc,
    output logic                              rsp_predicted_taken,
    output logic                              rsp_table_hit,
    output logic [btbp_pkg::SEQ_W-1:0]        rsp_seq_tag_out,
    output logic [btbp_pkg::STAT_W-1:0]       rsp_total_count,
    output logic [btbp_pkg::STAT_W-1:0]       rsp_correct_count
);

    localparam int TAG_W = (ADDR_BITS < btbp_pkg::PC_W) ? ADDR_BITS : btbp_pkg::PC_W;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [TAG_W-1:0]              tag_mem [TABLE_ENTRIES];
    logic [btbp_pkg::TGT_W-1:0]    tgt_mem [TABLE_ENTRIES];
    logic [btbp_pkg::DIR_W-1:0]    dir_mem [TABLE_ENTRIES];

    logic [btbp_pkg::FUNC_W-1:0]   func_reg;
    logic [TAG_W-1:0]              key_reg;
    logic [btbp_pkg::TGT_W-1:0]    target_reg;
    logic                          correct_reg;
    logic [btbp_pkg::SEQ_W-1:0]    seq_reg;

    logic [CNT_W-1:0]              scan_idx_reg;
    logic [CNT_W-1:0]              scan_idx_next;
    logic [CNT_W-1:0]              fill_reg;
    logic [CNT_W-1:0]              fill_next;
    logic                          rd_vld_reg;
    logic                          rd_vld_next;
    logic [TAG_W-1:0]              rd_tag_reg;
    logic [btbp_pkg::TGT_W-1:0]    rd_tgt_reg;
    logic [btbp_pkg::DIR_W-1:0]    rd_dir_reg;
    logic [IDX_W-1:0]              rd_idx_reg;

    logic [btbp_pkg::STAT_W-1:0]   upd_cnt_reg;
    logic [btbp_pkg::STAT_W-1:0]   upd_cnt_next;
    logic [btbp_pkg::STAT_W-1:0]   cor_cnt_reg;
    logic [btbp_pkg::STAT_W-1:0]   cor_cnt_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [btbp_pkg::PC_W-1:0]     out_next_pc_reg;
    logic [btbp_pkg::PC_W-1:0]     out_next_pc_next;
    logic                          out_taken_reg;
    logic                          out_taken_next;
    logic                          out_hit_reg;
    logic [btbp_pkg::SEQ_W-1:0]    out_seq_reg;
    logic [btbp_pkg::STAT_W-1:0]   out_total_reg;
    logic [btbp_pkg::STAT_W-1:0]   out_correct_reg;

    logic [IDX_W-1:0]              scan_addr;
    logic [IDX_W-1:0]              fill_addr;
    logic                          scan_more;
    logic                          rd_en;
    logic                          match;
    logic                          is_ins;
    logic                          is_pred;
    logic                          is_upd;
    logic                          ins_we;
    logic                          dir_we;
    logic                          out_load;
    logic                          taken;
    logic [TAG_W-1:0]              pc_inc;
    logic [btbp_pkg::DIR_W-1:0]    init_dir;

    assign scan_addr = scan_idx_reg[IDX_W-1:0];
    assign fill_addr = fill_reg[IDX_W-1:0];
    assign scan_more = scan_idx_reg < fill_reg;
    assign rd_en     = cmd.scan && scan_more;
    assign match     = rd_vld_reg && (rd_tag_reg == key_reg);

    assign is_ins  = func_reg == btbp_pkg::FUNC_INSERT;
    assign is_pred = func_reg == btbp_pkg::FUNC_PREDICT;
    assign is_upd  = func_reg == btbp_pkg::FUNC_UPDATE;

    assign status.hit      = match;
    assign status.miss     = !match && !rd_vld_reg && !scan_more;
    assign status.result   = is_pred || is_upd;
    assign status.out_full = out_valid_reg;

    assign ins_we   = cmd.commit && is_ins && !match && (fill_reg < CNT_W'(TABLE_ENTRIES));
    assign dir_we   = cmd.commit && is_upd && match && (mode >= btbp_pkg::MODE_ONE_BIT);
    assign out_load = cmd.commit && (is_pred || is_upd);
    assign init_dir = (mode == btbp_pkg::MODE_ONE_BIT) ? btbp_pkg::DIR_SNT : btbp_pkg::DIR_WNT;

    assign taken  = match && ((mode == btbp_pkg::MODE_STATIC_T) ||
                              ((mode >= btbp_pkg::MODE_ONE_BIT) && rd_dir_reg[1]));
    assign pc_inc = key_reg + TAG_W'(1);

    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        rd_vld_next   = rd_vld_reg;
        if (cmd.load)
        begin
            scan_idx_next = '0;
            rd_vld_next   = 1'b0;
        end
        else if (cmd.scan)
        begin
            rd_vld_next = scan_more;
            if (scan_more)
                scan_idx_next = scan_idx_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        fill_next    = ins_we ? fill_reg + CNT_W'(1) : fill_reg;
        upd_cnt_next = upd_cnt_reg;
        cor_cnt_next = cor_cnt_reg;
        if (cmd.commit && is_upd)
        begin
            if (!(&upd_cnt_reg))
                upd_cnt_next = upd_cnt_reg + btbp_pkg::STAT_W'(1);
            if (correct_reg && !(&cor_cnt_reg))
                cor_cnt_next = cor_cnt_reg + btbp_pkg::STAT_W'(1);
        end
    end

    always_comb
    begin
        if (is_upd)
        begin
            out_next_pc_next = '0;
            out_taken_next   = 1'b0;
        end
        else
        begin
            out_next_pc_next = taken ? rd_tgt_reg : btbp_pkg::PC_W'(pc_inc);
            out_taken_next   = taken;
        end

        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            fill_reg      <= '0;
            upd_cnt_reg   <= '0;
            cor_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scan_idx_reg  <= scan_idx_next;
            rd_vld_reg    <= rd_vld_next;
            fill_reg      <= fill_next;
            upd_cnt_reg   <= upd_cnt_next;
            cor_cnt_reg   <= cor_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg    <= req_func;
            key_reg     <= req_pc[TAG_W-1:0];
            target_reg  <= req_target;
            correct_reg <= req_was_correct;
            seq_reg     <= req_seq_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_tag_reg <= tag_mem[scan_addr];
            rd_tgt_reg <= tgt_mem[scan_addr];
            rd_dir_reg <= dir_mem[scan_addr];
            rd_idx_reg <= scan_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins_we)
        begin
            tag_mem[fill_addr] <= key_reg;
            tgt_mem[fill_addr] <= target_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins_we)
            dir_mem[fill_addr] <= init_dir;
        else if (dir_we)
            dir_mem[rd_idx_reg] <= btbp_pkg::next_dir(rd_dir_reg, correct_reg, mode);
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_next_pc_reg <= out_next_pc_next;
            out_taken_reg   <= out_taken_next;
            out_hit_reg     <= match;
            out_seq_reg     <= seq_reg;
            out_total_reg   <= upd_cnt_next;
            out_correct_reg <= cor_cnt_next;
        end
    end

    assign rsp_valid           = out_valid_reg;
    assign rsp_next_pc         = out_next_pc_reg;
    assign rsp_predicted_taken = out_taken_reg;
    assign rsp_table_hit       = out_hit_reg;
    assign rsp_seq_tag_out     = out_seq_reg;
    assign rsp_total_count     = out_total_reg;
    assign rsp_correct_count   = out_correct_reg;

endmodule

// ===== design/btb_branch_predictor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_branch_predictor
// Branch target buffer with static, one-bit and two-bit direction prediction.
// ----------------------------------------------------------------------------
//  Channel  Direction  Word
//  req      in         func, pc, target, was_correct, seq_tag
//  rsp      out        next_pc, predicted_taken, table_hit, seq_tag_out, counts
//  apb      in/out     predictor_mode register at byte address 0
//
//  A word on a miss scans all fill_count entries (none when the table is empty)
//  and on a hit stops at the matching entry, at most TABLE_ENTRIES; the entries are
//  searched one per cycle through the single read port of the tag memory.
//  Reset empties the table at once through the fill count; there is no
//  clearing pass. A full response register holds a finished update or predict
//  word, while the next request word is still accepted and searched.
// ----------------------------------------------------------------------------
module btb_branch_predictor
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int ADDR_BITS     = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    btbp_req_if.sink                            req,
    btbp_rsp_if.source                          rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [btbp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [btbp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [btbp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [btbp_pkg::MODE_W-1:0] mode_reg;
    logic [btbp_pkg::MODE_W-1:0] mode_next;
    logic                        reg_sel;
    btbp_pkg::cmd_t              cmd;
    btbp_pkg::status_t           status;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2] == btbp_pkg::REG_MODE;

    always_comb
    begin
        mode_next = mode_reg;
        if (psel && penable && pwrite && reg_sel)
            mode_next = pwdata[btbp_pkg::MODE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= btbp_pkg::MODE_RESET;
        else
            mode_reg <= mode_next;
    end

    assign prdata = reg_sel ? btbp_pkg::APB_DATA_W'(mode_reg) : '0;

    btbp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    btbp_dp
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_BITS     (ADDR_BITS)
    )
    u_dp
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .mode                (mode_reg),
        .req_func            (req.func),
        .req_pc              (req.pc),
        .req_target          (req.target),
        .req_was_correct     (req.was_correct),
        .req_seq_tag         (req.seq_tag),
        .rsp_ready           (rsp.ready),
        .rsp_valid           (rsp.valid),
        .rsp_next_pc         (rsp.next_pc),
        .rsp_predicted_taken (rsp.predicted_taken),
        .rsp_table_hit       (rsp.table_hit),
        .rsp_seq_tag_out     (rsp.seq_tag_out),
        .rsp_total_count     (rsp.total_count),
        .rsp_correct_count   (rsp.correct_count)
    );

endmodule

// ===== verif/tb_btb_branch_predictor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_btb_branch_predictor
// Self-checking testbench for the branch target buffer. A queue-fed driver
// sends request words and a monitor checks each response word against a
// behavioral copy of the table, its direction states and its counters. The run
// has a short directed opening, then random words in every predictor mode.
// Both sides are throttled in changing patterns.
// ----------------------------------------------------------------------------
module tb_btb_branch_predictor;

    localparam int TABLE_DEPTH    = 64;
    localparam int POOL_SIZE      = 96;
    localparam int SEGMENT_WORDS  = 150;
    localparam int SEGMENTS       = 8;
    localparam int BLOCK_LATENCY  = TABLE_DEPTH + 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [btbp_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [btbp_pkg::FUNC_W-1:0] func;
        logic [btbp_pkg::PC_W-1:0]   pc;
        logic [btbp_pkg::TGT_W-1:0]  target;
        logic                        was_correct;
        logic [btbp_pkg::SEQ_W-1:0]  seq_tag;
    } branch_word_t;

    typedef struct packed {
        logic [btbp_pkg::PC_W-1:0]   next_pc;
        logic                        predicted_taken;
        logic                        table_hit;
        logic [btbp_pkg::SEQ_W-1:0]  seq_tag_out;
        logic [btbp_pkg::STAT_W-1:0] total_count;
        logic [btbp_pkg::STAT_W-1:0] correct_count;
    } btb_answer_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [btbp_pkg::APB_ADDR_W-1:0] paddr;
    logic [btbp_pkg::APB_DATA_W-1:0] pwdata;
    logic [btbp_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    btbp_req_if req_ch ();
    btbp_rsp_if rsp_ch ();

    btb_branch_predictor dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    branch_word_t req_words[$];
    btb_answer_t  pending_answers[$];
    logic [btbp_pkg::PC_W-1:0] pc_pool [POOL_SIZE];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int stall_cycles;

    // Shadow of the block's table, direction states, counters and mode.
    logic [btbp_pkg::PC_W-1:0]   shadow_tag    [TABLE_DEPTH];
    logic [btbp_pkg::TGT_W-1:0]  shadow_target [TABLE_DEPTH];
    logic [btbp_pkg::DIR_W-1:0]  shadow_dir    [TABLE_DEPTH];
    int                          shadow_fill;
    logic [btbp_pkg::STAT_W-1:0] shadow_total;
    logic [btbp_pkg::STAT_W-1:0] shadow_correct;
    logic [btbp_pkg::MODE_W-1:0] shadow_mode;

    logic [btbp_pkg::MODE_W-1:0] segment_modes [SEGMENTS] = '{btbp_pkg::MODE_ONE_BIT,
        btbp_pkg::MODE_STATIC_NT, btbp_pkg::MODE_STATIC_T, btbp_pkg::MODE_TWO_BIT,
        btbp_pkg::MODE_ONE_BIT, btbp_pkg::MODE_STATIC_T, btbp_pkg::MODE_STATIC_NT,
        btbp_pkg::MODE_TWO_BIT};

    function automatic logic [btbp_pkg::DIR_W-1:0] advance_direction(
        input logic [btbp_pkg::DIR_W-1:0]  cur,
        input logic                        correct,
        input logic [btbp_pkg::MODE_W-1:0] mode
    );
        if (mode == btbp_pkg::MODE_ONE_BIT)
            return correct ? cur : (cur[1] ? btbp_pkg::DIR_SNT : btbp_pkg::DIR_ST);
        if (correct)
            return cur[1] ? btbp_pkg::DIR_ST : btbp_pkg::DIR_SNT;
        case (cur)
            btbp_pkg::DIR_ST:  return btbp_pkg::DIR_WT;
            btbp_pkg::DIR_WT:  return btbp_pkg::DIR_SNT;
            btbp_pkg::DIR_WNT: return btbp_pkg::DIR_ST;
            default:           return btbp_pkg::DIR_WNT;
        endcase
    endfunction

    // Applies one word to the shadow state; returns 1 when a response is due.
    function automatic bit branch_lookup_step(input branch_word_t w, output btb_answer_t ans);
        int   hit_idx;
        logic taken;
        hit_idx = -1;
        taken   = 1'b0;
        ans     = '0;
        for (int i = 0; i < shadow_fill; i++)
            if (shadow_tag[i] == w.pc)
                hit_idx = i;
        case (w.func)
            btbp_pkg::FUNC_INSERT:
            begin
                if (hit_idx < 0 && shadow_fill < TABLE_DEPTH)
                begin
                    shadow_tag[shadow_fill]    = w.pc;
                    shadow_target[shadow_fill] = w.target;
                    shadow_dir[shadow_fill]    = (shadow_mode == btbp_pkg::MODE_ONE_BIT) ?
                                                 btbp_pkg::DIR_SNT : btbp_pkg::DIR_WNT;
                    shadow_fill++;
                end
                return 1'b0;
            end
            btbp_pkg::FUNC_PREDICT:
            begin
                if (hit_idx >= 0)
                begin
                    if (shadow_mode == btbp_pkg::MODE_STATIC_T)
                        taken = 1'b1;
                    else if (shadow_mode == btbp_pkg::MODE_ONE_BIT ||
                             shadow_mode == btbp_pkg::MODE_TWO_BIT)
                        taken = shadow_dir[hit_idx][1];
                end
                ans.next_pc         = taken ? shadow_target[hit_idx] : w.pc + 1'b1;
                ans.predicted_taken = taken;
            end
            btbp_pkg::FUNC_UPDATE:
            begin
                if (shadow_total != '1)
                    shadow_total++;
                if (w.was_correct && shadow_correct != '1)
                    shadow_correct++;
                if (hit_idx >= 0 && (shadow_mode == btbp_pkg::MODE_ONE_BIT ||
                                     shadow_mode == btbp_pkg::MODE_TWO_BIT))
                    shadow_dir[hit_idx] = advance_direction(shadow_dir[hit_idx], w.was_correct,
                                                            shadow_mode);
            end
            default:
                return 1'b0;
        endcase
        ans.table_hit     = (hit_idx >= 0);
        ans.seq_tag_out   = w.seq_tag;
        ans.total_count   = shadow_total;
        ans.correct_count = shadow_correct;
        return 1'b1;
    endfunction

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        btb_answer_t ans;
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.func        <= btbp_pkg::FUNC_INSERT;
            req_ch.pc          <= '0;
            req_ch.target      <= '0;
            req_ch.was_correct <= 1'b0;
            req_ch.seq_tag     <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                if (branch_lookup_step({req_ch.func, req_ch.pc, req_ch.target,
                                        req_ch.was_correct, req_ch.seq_tag}, ans))
                    pending_answers.push_back(ans);
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    branch_word_t w;
                    w = req_words.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.func        <= w.func;
                    req_ch.pc          <= w.pc;
                    req_ch.target      <= w.target;
                    req_ch.was_correct <= w.was_correct;
                    req_ch.seq_tag     <= w.seq_tag;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor.
    always @(posedge clk or negedge rst_n)
    begin
        btb_answer_t got;
        btb_answer_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = {rsp_ch.next_pc, rsp_ch.predicted_taken, rsp_ch.table_hit,
                       rsp_ch.seq_tag_out, rsp_ch.total_count, rsp_ch.correct_count};
                if (pending_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected response word: next_pc %h seq %h", got.next_pc,
                                 got.seq_tag_out);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"mismatch (expected/actual): next_pc %h/%h taken %b/%b ",
                                      "hit %b/%b seq %h/%h total %0d/%0d correct %0d/%0d"},
                                     want.next_pc, got.next_pc, want.predicted_taken,
                                     got.predicted_taken, want.table_hit, got.table_hit,
                                     want.seq_tag_out, got.seq_tag_out, want.total_count,
                                     got.total_count, want.correct_count, got.correct_count);
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
                stall_cycles <= 0;
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_btb_branch_predictor NOT OK");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_word(
        input logic [btbp_pkg::FUNC_W-1:0] func,
        input logic [btbp_pkg::PC_W-1:0]   pc,
        input logic [btbp_pkg::TGT_W-1:0]  target,
        input logic                        was_correct,
        input logic [btbp_pkg::SEQ_W-1:0]  seq_tag
    );
        req_words.push_back({func, pc, target, was_correct, seq_tag});
    endtask

    // Queues one word with a random target, outcome and sequence tag.
    task automatic push_random(
        input logic [btbp_pkg::FUNC_W-1:0] func,
        input logic [btbp_pkg::PC_W-1:0]   pc
    );
        push_word(func, pc, btbp_pkg::TGT_W'($urandom_range(65535)), 1'($urandom_range(1)),
                  btbp_pkg::SEQ_W'($urandom_range(255)));
    endtask

    function automatic logic [btbp_pkg::PC_W-1:0] pick_pc();
        if ($urandom_range(99) < 85)
            return pc_pool[$urandom_range(POOL_SIZE - 1)];
        return btbp_pkg::PC_W'($urandom_range(65535));
    endfunction

    // Mostly predict/update pairs on known branches, with inserts and noise.
    task automatic queue_random_words(input int count);
        int                        n;
        int                        pick;
        logic [btbp_pkg::PC_W-1:0] addr;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(99);
            addr = pick_pc();
            if (pick < 15)
            begin
                push_random(btbp_pkg::FUNC_INSERT, addr);
                n++;
            end
            else if (pick < 80)
            begin
                push_random(btbp_pkg::FUNC_PREDICT, addr);
                push_random(btbp_pkg::FUNC_UPDATE, addr);
                n += 2;
            end
            else if (pick < 88)
            begin
                push_random(btbp_pkg::FUNC_UPDATE, addr);
                n++;
            end
            else if (pick < 96)
            begin
                push_random(btbp_pkg::FUNC_PREDICT, addr);
                n++;
            end
            else
                push_random(FUNC_UNUSED, addr);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (req_words.size() != 0 || req_ch.valid || pending_answers.size() != 0);
        repeat (BLOCK_LATENCY) @(posedge clk);
    endtask

    task automatic write_mode(input logic [btbp_pkg::MODE_W-1:0] mode);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {btbp_pkg::REG_MODE, 2'b00};
        pwdata  <= btbp_pkg::APB_DATA_W'(mode);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        shadow_mode = mode;
    endtask

    initial
    begin
        req_ch.valid       = 1'b0;
        req_ch.func        = btbp_pkg::FUNC_INSERT;
        req_ch.pc          = '0;
        req_ch.target      = '0;
        req_ch.was_correct = 1'b0;
        req_ch.seq_tag     = '0;
        rsp_ch.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        rst_n              = 1'b0;
        send_idle_pct      = 33;
        recv_idle_pct      = 73;
        mismatches         = 0;
        stall_cycles       = 0;
        shadow_fill        = 0;
        shadow_total       = '0;
        shadow_correct     = '0;
        shadow_mode        = btbp_pkg::MODE_RESET;

        pc_pool[0] = 16'hFFFF;
        pc_pool[1] = 16'h0000;
        for (int i = 2; i < POOL_SIZE; i++)
            pc_pool[i] = btbp_pkg::PC_W'($urandom_range(65535));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Opening checks in the reset mode, which is two-bit.
        push_word(btbp_pkg::FUNC_PREDICT, 16'hFFFF, 16'h0000, 1'b1, 8'h00);
        push_word(btbp_pkg::FUNC_UPDATE,  16'h1234, 16'hFFFF, 1'b1, 8'hFF);
        push_word(btbp_pkg::FUNC_INSERT,  16'hFFFF, 16'h0000, 1'b0, 8'h01);
        push_word(btbp_pkg::FUNC_INSERT,  16'h0000, 16'hFFFF, 1'b0, 8'h02);
        push_word(btbp_pkg::FUNC_INSERT,  16'hFFFF, 16'h5A5A, 1'b1, 8'h03);
        push_word(btbp_pkg::FUNC_PREDICT, 16'hFFFF, 16'hA5A5, 1'b0, 8'h04);
        push_word(btbp_pkg::FUNC_UPDATE,  16'hFFFF, 16'h0000, 1'b0, 8'h05);
        push_word(btbp_pkg::FUNC_PREDICT, 16'hFFFF, 16'h0000, 1'b0, 8'h06);
        push_word(btbp_pkg::FUNC_UPDATE,  16'hFFFF, 16'h0000, 1'b0, 8'h07);
        push_word(btbp_pkg::FUNC_PREDICT, 16'hFFFF, 16'h0000, 1'b1, 8'h08);
        push_word(btbp_pkg::FUNC_UPDATE,  16'hFFFF, 16'h0000, 1'b0, 8'h09);
        push_word(btbp_pkg::FUNC_UPDATE,  16'hFFFF, 16'h0000, 1'b1, 8'h0A);
        push_word(btbp_pkg::FUNC_UPDATE,  16'hFFFF, 16'h0000, 1'b0, 8'h0B);
        push_word(btbp_pkg::FUNC_UPDATE,  16'hFFFF, 16'h0000, 1'b1, 8'h0C);
        push_word(btbp_pkg::FUNC_UPDATE,  16'h0000, 16'h0000, 1'b0, 8'h0D);
        push_word(btbp_pkg::FUNC_UPDATE,  16'h0000, 16'h0000, 1'b1, 8'h0E);
        push_word(btbp_pkg::FUNC_PREDICT, 16'h0000, 16'h0000, 1'b0, 8'h0F);
        push_word(FUNC_UNUSED,            16'hAAAA, 16'h5555, 1'b1, 8'h7F);
        push_word(btbp_pkg::FUNC_PREDICT, 16'h0000, 16'hFFFF, 1'b1, 8'hFF);

        for (int s = 0; s < SEGMENTS; s++)
        begin
            wait_drained();
            write_mode(segment_modes[s]);
            if (s < 3)
            begin
                send_idle_pct = 33;
                recv_idle_pct = 73;
            end
            else if (s < 6)
            begin
                send_idle_pct = 73;
                recv_idle_pct = 33;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            queue_random_words(SEGMENT_WORDS);
        end

        wait_drained();
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("tb_btb_branch_predictor OK");
        else
            $display("tb_btb_branch_predictor NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
design/btbp_pkg.sv
design/btbp_if.sv
design/btbp_ctrl.sv
design/btbp_dp.sv
design/btb_branch_predictor.sv
verif/tb_btb_branch_predictor.sv
